### hw/rtl/rpnse_pkg.sv
// rpnse_pkg: shared types and constants for the RPN stack evaluator.
// No dependencies; used by the channel interfaces and every RTL module.
package rpnse_pkg;

   localparam int DATA_W      = 32;
   localparam int KIND_W      = 3;
   localparam int COUNT_OUT_W = 5;
   localparam int STATUS_W    = 2;

   localparam logic [KIND_W-1:0] KIND_PUSH = 3'd0;
   localparam logic [KIND_W-1:0] KIND_POP  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SET  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ADD  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_MUL  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_DIST = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;

   typedef struct packed {
      logic load;    // request accepted: latch it, start the second-entry read
      logic commit;  // execute the latched request and load the response register
   } ctrl_cmd_type;

endpackage

### hw/rtl/rpnse_if.sv
// rpnse_if: valid/ready channel interfaces for requests and responses.
// Depends on rpnse_pkg for field widths.
interface rpnse_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [rpnse_pkg::KIND_W-1:0]           kind;
   logic signed [rpnse_pkg::DATA_W-1:0]    operand;

   modport source (output valid, output kind, output operand, input ready);
   modport sink   (input valid, input kind, input operand, output ready);
endinterface

interface rpnse_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [rpnse_pkg::DATA_W-1:0]    popped_value;
   logic signed [rpnse_pkg::DATA_W-1:0]    top_value;
   logic                                   is_empty;
   logic [rpnse_pkg::COUNT_OUT_W-1:0]      entry_count;
   logic [rpnse_pkg::STATUS_W-1:0]         status;

   modport source (output valid, output popped_value, output top_value, output is_empty,
                   output entry_count, output status, input ready);
   modport sink   (input valid, input popped_value, input top_value, input is_empty,
                   input entry_count, input status, output ready);
endinterface

### hw/rtl/rpnse_ctrl.sv
// rpnse_ctrl: request sequencing and response-valid control.
// Depends on rpnse_pkg (ctrl_cmd_type).
module rpnse_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rpnse_pkg::ctrl_cmd_type cmd
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign cmd.load   = req_valid && (state_ff == S_IDLE);
   assign cmd.commit = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (cmd.load) state_ff <= S_EXEC;
            end
            S_EXEC: begin
               if (cmd.commit) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

### hw/rtl/rpnse_datapath.sv
// rpnse_datapath: top-of-stack register, stack memory, ALU and response register.
// Depends on rpnse_pkg (widths, kind and status codes, ctrl_cmd_type).
module rpnse_datapath #(
   parameter int STACK_DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  rpnse_pkg::ctrl_cmd_type                cmd,
   input  logic [rpnse_pkg::KIND_W-1:0]           req_kind,
   input  logic signed [rpnse_pkg::DATA_W-1:0]    req_operand,
   output logic signed [rpnse_pkg::DATA_W-1:0]    rsp_popped_value,
   output logic signed [rpnse_pkg::DATA_W-1:0]    rsp_top_value,
   output logic                                   rsp_is_empty,
   output logic [rpnse_pkg::COUNT_OUT_W-1:0]      rsp_entry_count,
   output logic [rpnse_pkg::STATUS_W-1:0]         rsp_status
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int DW = rpnse_pkg::DATA_W;

   // memory holds every entry below the top; the top lives in top_ff
   logic [DW-1:0]                    mem [STACK_DEPTH];
   logic [DW-1:0]                    rdata_ff;
   logic [DW-1:0]                    top_ff, top_in;
   logic [CW-1:0]                    count_ff, count_in;
   logic [rpnse_pkg::KIND_W-1:0]     kind_ff;
   logic [DW-1:0]                    operand_ff;

   logic signed [DW-1:0]             popped_ff, top_out_ff;
   logic                             empty_ff;
   logic [rpnse_pkg::COUNT_OUT_W-1:0] count_out_ff;
   logic [rpnse_pkg::STATUS_W-1:0]   status_ff;

   logic                             has1, has2, full;
   logic [AW-1:0]                    rd_addr, wr_addr;
   logic                             wr_en;
   logic [DW-1:0]                    popped_in, alu_res, diff, prod;
   logic [rpnse_pkg::STATUS_W-1:0]   status_in;

   assign has1    = (count_ff != '0);
   assign has2    = (count_ff >= CW'(2));
   assign full    = (count_ff == CW'(STACK_DEPTH));
   assign rd_addr = has2 ? AW'(count_ff - CW'(2)) : '0;
   assign wr_addr = AW'(count_ff - CW'(1));

   assign diff = top_ff - rdata_ff;
   assign prod = top_ff * rdata_ff;

   always_comb begin
      case (kind_ff)
         rpnse_pkg::KIND_ADD: alu_res = top_ff + rdata_ff;
         rpnse_pkg::KIND_MUL: alu_res = prod;
         default:             alu_res = diff[DW-1] ? (DW'(0) - diff) : diff;
      endcase
   end

   always_comb begin
      count_in  = count_ff;
      top_in    = top_ff;
      popped_in = '0;
      status_in = rpnse_pkg::ST_OK;
      wr_en     = 1'b0;
      case (kind_ff)
         rpnse_pkg::KIND_PUSH: begin
            if (full) begin
               status_in = rpnse_pkg::ST_OVER;
            end else begin
               wr_en    = has1;
               top_in   = operand_ff;
               count_in = count_ff + CW'(1);
            end
         end
         rpnse_pkg::KIND_POP: begin
            if (!has1) begin
               status_in = rpnse_pkg::ST_UNDER;
            end else begin
               popped_in = top_ff;
               top_in    = has2 ? rdata_ff : '0;
               count_in  = count_ff - CW'(1);
            end
         end
         rpnse_pkg::KIND_SET: begin
            if (!has1) status_in = rpnse_pkg::ST_UNDER;
            else       top_in    = operand_ff;
         end
         rpnse_pkg::KIND_ADD, rpnse_pkg::KIND_MUL, rpnse_pkg::KIND_DIST: begin
            if (!has2) begin
               status_in = rpnse_pkg::ST_UNDER;
            end else begin
               top_in   = alu_res;
               count_in = count_ff - CW'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) rdata_ff <= mem[rd_addr];
      if (cmd.commit && wr_en) mem[wr_addr] <= top_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff    <= req_kind;
         operand_ff <= req_operand;
      end
      if (cmd.commit) begin
         top_ff       <= top_in;
         popped_ff    <= popped_in;
         top_out_ff   <= (count_in == '0) ? '0 : top_in;
         empty_ff     <= (count_in == '0);
         count_out_ff <= rpnse_pkg::COUNT_OUT_W'(count_in);
         status_ff    <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.commit) begin
         count_ff <= count_in;
      end
   end

   assign rsp_popped_value = popped_ff;
   assign rsp_top_value    = top_out_ff;
   assign rsp_is_empty     = empty_ff;
   assign rsp_entry_count  = count_out_ff;
   assign rsp_status       = status_ff;

endmodule

### hw/rtl/rpn_stack_evaluator_core.sv
// rpn_stack_evaluator_core: top level of the RPN stack evaluator.
// Depends on rpnse_pkg, rpnse_if, rpnse_ctrl and rpnse_datapath.
//
// Each request (push, pop, set top, add, multiply, absolute difference) yields
// one response with the popped value, new top, empty flag, entry count and
// status. Each request first does a registered read of the second stack entry
// from the single-port stack memory, then computes and commits against the
// top-of-stack register. A new request is taken while the previous
// response is still held; the commit waits only if that response has not yet
// been taken. Stack memory needs no clearing pass after reset.
module rpn_stack_evaluator_core #(
   parameter int STACK_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   rpnse_req_if.sink   req,
   rpnse_rsp_if.source rsp
);

   rpnse_pkg::ctrl_cmd_type cmd;

   rpnse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd)
   );

   rpnse_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_kind         (req.kind),
      .req_operand      (req.operand),
      .rsp_popped_value (rsp.popped_value),
      .rsp_top_value    (rsp.top_value),
      .rsp_is_empty     (rsp.is_empty),
      .rsp_entry_count  (rsp.entry_count),
      .rsp_status       (rsp.status)
   );

`ifndef SYNTH
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("request accepted while another is in flight");

   a_empty_top_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.is_empty) |-> (rsp.top_value == '0))
      else $error("empty stack reports nonzero top");

   a_fail_no_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.status != rpnse_pkg::ST_OK)) |-> (rsp.popped_value == '0))
      else $error("failed request reports a popped value");
`endif

endmodule
